// ----- hw/rtl/bce_pkg.sv -----
package bce_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int MAX_DEGREE  = 3;
   localparam int KNOT_DEPTH  = MAX_POINTS + 4;
   localparam int PT_AW       = $clog2(MAX_POINTS);
   localparam int IDX_W       = 7;
   localparam int T_W         = 48;
   localparam int V_W         = 32;
   localparam int SIG_W       = 31;
   localparam int DIFF_W      = T_W + 1;
   localparam int DIV_W       = T_W + 2;
   localparam int FRAC_W      = 30;
   localparam int RND_W       = 34;
   localparam int ACC_W       = 36;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic signed [V_W-1:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic signed [V_W-1:0] W_MAX   = 32'sh7fff_ffff;
   localparam logic signed [V_W-1:0] W_MIN   = 32'sh8000_0000;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_KNOT   = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_DEGREE      = 2'd0,
      CSR_POINT_COUNT = 2'd1,
      CSR_TIME_LOW    = 2'd2,
      CSR_TIME_HIGH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] count;
      logic [1:0]       degree;
   } cfg_type;

   typedef struct packed {
      kind_type                kind;
      logic [IDX_W-1:0]        slot;
      logic signed [T_W-1:0]   stamp;
      logic signed [V_W-1:0]   x;
      logic signed [V_W-1:0]   y;
      logic signed [V_W-1:0]   z;
      logic signed [V_W-1:0]   s;
   } cmd_type;

   typedef struct packed {
      logic signed [T_W-1:0] clamped_time;
      logic signed [V_W-1:0] out_x;
      logic signed [V_W-1:0] out_y;
      logic signed [V_W-1:0] out_z;
      logic [SIG_W-1:0]      out_sigma;
      logic                  used_spline;
      logic [IDX_W-1:0]      span_index;
   } rsp_type;

endpackage

// ----- hw/rtl/bce_req_if.sv -----
interface bce_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            kind;
   logic [bce_pkg::IDX_W-1:0]             slot;
   logic signed [bce_pkg::T_W-1:0]        time_value;
   logic signed [bce_pkg::V_W-1:0]        pos_x;
   logic signed [bce_pkg::V_W-1:0]        pos_y;
   logic signed [bce_pkg::V_W-1:0]        pos_z;
   logic signed [bce_pkg::V_W-1:0]        uncertainty;

   modport source (output valid, kind, slot, time_value, pos_x, pos_y, pos_z, uncertainty,
                   input ready);
   modport sink   (input valid, kind, slot, time_value, pos_x, pos_y, pos_z, uncertainty,
                   output ready);
endinterface

// ----- hw/rtl/bce_rsp_if.sv -----
interface bce_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [bce_pkg::T_W-1:0]        clamped_time;
   logic signed [bce_pkg::V_W-1:0]        out_x;
   logic signed [bce_pkg::V_W-1:0]        out_y;
   logic signed [bce_pkg::V_W-1:0]        out_z;
   logic [bce_pkg::SIG_W-1:0]             out_sigma;
   logic                                  used_spline;
   logic [bce_pkg::IDX_W-1:0]             span_index;

   modport source (output valid, clamped_time, out_x, out_y, out_z, out_sigma, used_spline,
                   span_index, input ready);
   modport sink   (input valid, clamped_time, out_x, out_y, out_z, out_sigma, used_spline,
                   span_index, output ready);
endinterface

// ----- hw/rtl/bce_csr_if.sv -----
interface bce_csr_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  index;
   logic [bce_pkg::T_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bspline_curve_evaluator_top.sv -----
// channel   dir  handshake     payload
// req_ch    in   valid/ready   kind, slot, time_value, pos_x, pos_y, pos_z, uncertainty
// rsp_ch    out  valid/ready   clamped_time, out_x, out_y, out_z, out_sigma, used_spline,
//                              span_index
// csr_ch    in   valid/ready   index, data (always ready)
//
// The back end writes each load into its table as it pops it; the front queue holds two beats.
// A linear query scans the points for the bracketing pair, runs the serial divider
// for the ratio and blends the one or two points it found.
// A spline query searches for the knot span, reads its knots and builds the weights
// before it blends the points; two dividers work each weight pair.
// Reset is synchronous and clears the configuration and control state only.
// The result sits in an output register; a stalled rsp_ch holds the back end only
// once a second result is ready.
module bspline_curve_evaluator_top (
   input logic        clock,
   input logic        reset,
   bce_req_if.sink    req_ch,
   bce_rsp_if.source  rsp_ch,
   bce_csr_if.sink    csr_ch
);

   bce_pkg::cfg_type  cfg;
   logic              push;
   bce_pkg::cmd_type  push_data;
   logic              full;
   logic              q_valid;
   logic              q_pop;
   bce_pkg::cmd_type  q_data;
   logic              rsp_valid;
   bce_pkg::rsp_type  rsp_data;

   bce_front u_front (
      .clock (clock), .reset (reset), .req (req_ch), .csr (csr_ch), .cfg (cfg),
      .push  (push), .push_data (push_data), .full (full)
   );

   bce_fifo u_fifo (
      .clock (clock), .reset (reset), .push (push), .push_data (push_data), .full (full),
      .valid (q_valid), .pop (q_pop), .pop_data (q_data)
   );

   bce_back u_back (
      .clock (clock), .reset (reset), .cfg (cfg), .q_valid (q_valid), .q_pop (q_pop),
      .q_data (q_data), .rsp_valid (rsp_valid), .rsp_ready (rsp_ch.ready),
      .rsp_data (rsp_data)
   );

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.clamped_time = rsp_data.clamped_time;
   assign rsp_ch.out_x        = rsp_data.out_x;
   assign rsp_ch.out_y        = rsp_data.out_y;
   assign rsp_ch.out_z        = rsp_data.out_z;
   assign rsp_ch.out_sigma    = rsp_data.out_sigma;
   assign rsp_ch.used_spline  = rsp_data.used_spline;
   assign rsp_ch.span_index   = rsp_data.span_index;

endmodule

// ----- hw/rtl/bce_front.sv -----
module bce_front (
   input  logic              clock,
   input  logic              reset,
   bce_req_if.sink           req,
   bce_csr_if.sink           csr,
   output bce_pkg::cfg_type  cfg,
   output logic              push,
   output bce_pkg::cmd_type  push_data,
   input  logic              full
);

   logic [1:0]                       degree_ff;
   logic [bce_pkg::IDX_W-1:0]        count_ff;
   logic signed [bce_pkg::T_W-1:0]   tlo_ff;
   logic signed [bce_pkg::T_W-1:0]   thi_ff;
   logic                             keep;
   bce_pkg::kind_type                kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 2'(bce_pkg::MAX_DEGREE);
         count_ff  <= '0;
         tlo_ff    <= '0;
         thi_ff    <= '0;
      end else if (csr.valid) begin
         case (bce_pkg::csr_index_type'(csr.index))
            bce_pkg::CSR_DEGREE:      degree_ff <= csr.data[1:0];
            bce_pkg::CSR_POINT_COUNT: count_ff  <= csr.data[bce_pkg::IDX_W-1:0];
            bce_pkg::CSR_TIME_LOW:    tlo_ff    <= $signed(csr.data);
            bce_pkg::CSR_TIME_HIGH:   thi_ff    <= $signed(csr.data);
            default: ;
         endcase
      end
   end

   assign csr.ready = 1'b1;

   always_comb begin
      cfg.count = (count_ff > bce_pkg::IDX_W'(bce_pkg::MAX_POINTS)) ?
                  bce_pkg::IDX_W'(bce_pkg::MAX_POINTS) : count_ff;
      if (degree_ff == 2'd0)
         cfg.degree = 2'd1;
      else if (degree_ff > 2'(bce_pkg::MAX_DEGREE))
         cfg.degree = 2'(bce_pkg::MAX_DEGREE);
      else
         cfg.degree = degree_ff;
   end

   assign req.ready = !full;
   assign kind      = bce_pkg::kind_type'(req.kind);

   // classify: drop unused kinds, out-of-range loads and queries with no points
   always_comb begin
      case (kind)
         bce_pkg::KIND_POINT: keep = req.slot < bce_pkg::IDX_W'(bce_pkg::MAX_POINTS);
         bce_pkg::KIND_KNOT:  keep = req.slot < bce_pkg::IDX_W'(bce_pkg::KNOT_DEPTH);
         bce_pkg::KIND_QUERY: keep = cfg.count != '0;
         default:             keep = 1'b0;
      endcase
   end

   assign push = req.valid && req.ready && keep;

   always_comb begin
      push_data.kind = kind;
      push_data.slot = req.slot;
      push_data.x    = req.pos_x;
      push_data.y    = req.pos_y;
      push_data.z    = req.pos_z;
      push_data.s    = req.uncertainty;
      if (kind != bce_pkg::KIND_QUERY)
         push_data.stamp = req.time_value;
      else if (req.time_value < tlo_ff)
         push_data.stamp = tlo_ff;
      else if (req.time_value > thi_ff)
         push_data.stamp = thi_ff;
      else
         push_data.stamp = req.time_value;
   end

endmodule

// ----- hw/rtl/bce_fifo.sv -----
module bce_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bce_pkg::cmd_type  push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output bce_pkg::cmd_type  pop_data
);

   bce_pkg::cmd_type                 mem [bce_pkg::QUEUE_DEPTH];
   logic [bce_pkg::QUEUE_AW-1:0]     wp_ff;
   logic [bce_pkg::QUEUE_AW-1:0]     rp_ff;
   logic [bce_pkg::QUEUE_AW:0]       cnt_ff;

   assign full     = cnt_ff == (bce_pkg::QUEUE_AW+1)'(bce_pkg::QUEUE_DEPTH);
   assign valid    = cnt_ff != '0;
   assign pop_data = mem[rp_ff];

   always_ff @(posedge clock) begin
      if (push)
         mem[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)
            wp_ff <= wp_ff + 1'b1;
         if (pop)
            rp_ff <= rp_ff + 1'b1;
         if (push && !pop)
            cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push)
            cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// ----- hw/rtl/bce_div.sv -----
module bce_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [bce_pkg::DIV_W-1:0]    num,
   input  logic signed [bce_pkg::DIV_W-1:0]    den,
   output logic                                busy,
   output logic signed [bce_pkg::V_W-1:0]      quot
);

   logic                               busy_ff;
   logic [4:0]                         cnt_ff;
   logic [bce_pkg::DIV_W-1:0]          rem_ff;
   logic [bce_pkg::DIV_W-1:0]          dv_ff;
   logic [bce_pkg::FRAC_W:0]           q_ff;
   logic                               neg_ff;
   logic signed [bce_pkg::V_W-1:0]     quot_ff;

   logic [bce_pkg::DIV_W-1:0]          un;
   logic [bce_pkg::DIV_W-1:0]          ud;
   logic [bce_pkg::DIV_W:0]            sh;
   logic                               bit_in;
   logic [bce_pkg::FRAC_W:0]           qn;
   logic [bce_pkg::V_W-1:0]            qx;

   always_comb begin
      un     = num[bce_pkg::DIV_W-1] ? (~num + 1'b1) : num;
      ud     = den[bce_pkg::DIV_W-1] ? (~den + 1'b1) : den;
      sh     = {rem_ff, 1'b0};
      bit_in = sh >= {1'b0, dv_ff};
      qn     = {q_ff[bce_pkg::FRAC_W-1:0], bit_in};
      qx     = {1'b0, qn};
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         neg_ff <= num[bce_pkg::DIV_W-1] ^ den[bce_pkg::DIV_W-1];
         dv_ff  <= ud;
         if (ud == '0) begin
            quot_ff <= '0;
            busy_ff <= 1'b0;
         end else if ({1'b0, un} >= {ud, 1'b0}) begin
            quot_ff <= (num[bce_pkg::DIV_W-1] ^ den[bce_pkg::DIV_W-1]) ?
                       bce_pkg::W_MIN : bce_pkg::W_MAX;
            busy_ff <= 1'b0;
         end else begin
            // integer bit first, then one fraction bit a cycle
            q_ff    <= (bce_pkg::FRAC_W+1)'(un >= ud);
            rem_ff  <= (un >= ud) ? (un - ud) : un;
            cnt_ff  <= 5'(bce_pkg::FRAC_W);
            busy_ff <= 1'b1;
         end
      end else if (busy_ff) begin
         rem_ff <= bit_in ? bce_pkg::DIV_W'(sh - {1'b0, dv_ff}) : sh[bce_pkg::DIV_W-1:0];
         q_ff   <= qn;
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_ff <= 1'b0;
            quot_ff <= neg_ff ? $signed(~qx + 1'b1) : $signed(qx);
         end
      end
   end

endmodule

// ----- hw/rtl/bce_back.sv -----
module bce_back (
   input  logic              clock,
   input  logic              reset,
   input  bce_pkg::cfg_type  cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  bce_pkg::cmd_type  q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bce_pkg::rsp_type  rsp_data
);

   localparam int IW = bce_pkg::IDX_W;
   localparam int DW = bce_pkg::DIFF_W;
   localparam int AW = bce_pkg::ACC_W;
   localparam int VW = bce_pkg::V_W;
   localparam logic signed [AW-1:0] ACC_MAX = AW'(bce_pkg::W_MAX);
   localparam logic signed [AW-1:0] ACC_MIN = AW'(bce_pkg::W_MIN);

   typedef struct packed {
      logic signed [bce_pkg::T_W-1:0] stamp;
      logic signed [VW-1:0]           x;
      logic signed [VW-1:0]           y;
      logic signed [VW-1:0]           z;
      logic signed [VW-1:0]           s;
   } pt_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LSCAN, ST_LRATIO, ST_LDIV, ST_SPAN_END, ST_SEARCH, ST_KREAD, ST_KDATA,
      ST_COX_DIV, ST_COX_WAIT, ST_COX_MA, ST_COX_MB, ST_COX_MC, ST_BREAD, ST_BMUL,
      ST_BACC, ST_OUT
   } state_type;

   function automatic logic signed [VW-1:0] sat_w(input logic signed [AW-1:0] v);
      if (v > ACC_MAX)
         return bce_pkg::W_MAX;
      else if (v < ACC_MIN)
         return bce_pkg::W_MIN;
      else
         return v[VW-1:0];
   endfunction

   function automatic logic signed [bce_pkg::RND_W-1:0] rnd(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sh2000_0000;
      return s[63:64-bce_pkg::RND_W];
   endfunction

   pt_entry_type                       pt_mem [bce_pkg::MAX_POINTS];
   logic signed [bce_pkg::T_W-1:0]     kn_mem [bce_pkg::KNOT_DEPTH];
   pt_entry_type                       pt_rd_ff;
   logic signed [bce_pkg::T_W-1:0]     kn_a_ff;
   logic signed [bce_pkg::T_W-1:0]     kn_b_ff;

   state_type                          state_ff;
   logic signed [bce_pkg::T_W-1:0]     t_ff;
   logic signed [bce_pkg::T_W-1:0]     prev_ff;
   logic [IW-1:0]                      idx_ff;
   logic signed [DW-1:0]               dt_ff;
   logic signed [DW-1:0]               off_ff;
   logic [IW-1:0]                      span_ff;
   logic [IW-1:0]                      low_ff;
   logic [IW-1:0]                      high_ff;
   logic [IW-1:0]                      mid_ff;
   logic [1:0]                         j_ff;
   logic [1:0]                         r_ff;
   logic [1:0]                         k_ff;
   logic [1:0]                         c_ff;
   logic [1:0]                         last_ff;
   logic [IW-1:0]                      base_ff;
   logic signed [DW-1:0]               left_ff  [1:bce_pkg::MAX_DEGREE];
   logic signed [DW-1:0]               right_ff [1:bce_pkg::MAX_DEGREE];
   logic signed [VW-1:0]               w_ff     [bce_pkg::MAX_DEGREE+1];
   logic signed [VW-1:0]               saved_ff;
   logic signed [AW-1:0]               acc_ff   [4];
   logic                               spline_ff;
   logic signed [63:0]                 prod_ff;
   logic                               rsp_valid_ff;
   bce_pkg::rsp_type                   rsp_ff;

   logic                               pt_re;
   logic [bce_pkg::PT_AW-1:0]          pt_raddr;
   logic                               kn_re;
   logic [IW-1:0]                      ka;
   logic [IW-1:0]                      kb;
   logic signed [VW-1:0]               mul_a;
   logic signed [VW-1:0]               mul_b;
   logic                               div_start0;
   logic                               div_start1;
   logic signed [bce_pkg::DIV_W-1:0]   div_num0;
   logic signed [bce_pkg::DIV_W-1:0]   div_num1;
   logic signed [bce_pkg::DIV_W-1:0]   div_den;
   logic                               busy0;
   logic                               busy1;
   logic signed [VW-1:0]               q0;
   logic signed [VW-1:0]               q1;

   logic                               scan_go;
   logic                               search_go;
   logic [IW-1:0]                      lo_n;
   logic [IW-1:0]                      hi_n;
   logic [IW:0]                        sum0;
   logic [IW:0]                        sum_n;
   logic [IW-1:0]                      idx_inc;
   logic [IW-1:0]                      baddr;
   logic signed [DW-1:0]               dtf;
   logic                               off_le0;
   logic [1:0]                         r_inc;
   logic [1:0]                         jr;
   logic signed [VW-1:0]               chan;
   logic signed [VW-1:0]               sv_in;
   logic signed [AW-1:0]               sig_acc;

   always_comb begin
      scan_go   = (idx_ff < cfg.count) && (pt_rd_ff.stamp < t_ff);
      search_go = ((high_ff - low_ff) > IW'(1)) && (t_ff < kn_a_ff || t_ff >= kn_b_ff);
      lo_n      = (t_ff < kn_a_ff) ? low_ff : mid_ff;
      hi_n      = (t_ff < kn_a_ff) ? mid_ff : high_ff;
      sum0      = (IW+1)'(cfg.degree) + (IW+1)'(cfg.count);
      sum_n     = (IW+1)'(lo_n) + (IW+1)'(hi_n);
      idx_inc   = idx_ff + IW'(1);
      baddr     = base_ff + IW'(k_ff);
      dtf       = (dt_ff < DW'(1)) ? DW'(1) : dt_ff;
      off_le0   = off_ff[DW-1] || (off_ff == '0);
      r_inc     = r_ff + 2'd1;
      jr        = j_ff - r_ff;
      sv_in     = sat_w(AW'(rnd(prod_ff)));
      case (c_ff)
         2'd0:    chan = pt_rd_ff.x;
         2'd1:    chan = pt_rd_ff.y;
         2'd2:    chan = pt_rd_ff.z;
         default: chan = pt_rd_ff.s;
      endcase
   end

   always_comb begin
      q_pop      = 1'b0;
      pt_re      = 1'b0;
      pt_raddr   = '0;
      kn_re      = 1'b0;
      ka         = '0;
      kb         = '0;
      mul_a      = '0;
      mul_b      = '0;
      div_start0 = 1'b0;
      div_start1 = 1'b0;
      div_num0   = bce_pkg::DIV_W'(off_ff);
      div_num1   = bce_pkg::DIV_W'(left_ff[jr]);
      div_den    = bce_pkg::DIV_W'(dtf);
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid && q_data.kind == bce_pkg::KIND_QUERY) begin
               if (cfg.count < IW'(4)) begin
                  pt_re = 1'b1;
               end else begin
                  kn_re = 1'b1;
                  ka    = cfg.count;
                  kb    = IW'(cfg.degree);
               end
            end
         end
         ST_LSCAN: begin
            pt_re    = scan_go;
            pt_raddr = idx_inc[bce_pkg::PT_AW-1:0];
         end
         ST_LRATIO: begin
            div_start0 = !off_le0 && (off_ff < dtf);
         end
         ST_SPAN_END: begin
            kn_re = 1'b1;
            ka    = sum0[IW:1];
            kb    = sum0[IW:1] + IW'(1);
         end
         ST_SEARCH: begin
            kn_re = search_go;
            ka    = sum_n[IW:1];
            kb    = sum_n[IW:1] + IW'(1);
         end
         ST_KREAD: begin
            kn_re = 1'b1;
            ka    = span_ff + IW'(1) - IW'(j_ff);
            kb    = span_ff + IW'(j_ff);
         end
         ST_COX_DIV: begin
            div_start0 = 1'b1;
            div_start1 = 1'b1;
            div_num0   = bce_pkg::DIV_W'(right_ff[r_inc]);
            div_den    = bce_pkg::DIV_W'(right_ff[r_inc]) + bce_pkg::DIV_W'(left_ff[jr]);
         end
         ST_COX_MA: begin
            mul_a = w_ff[r_ff];
            mul_b = q0;
         end
         ST_COX_MB: begin
            mul_a = w_ff[r_ff];
            mul_b = q1;
         end
         ST_BREAD: begin
            pt_re    = 1'b1;
            pt_raddr = baddr[bce_pkg::PT_AW-1:0];
         end
         ST_BMUL: begin
            mul_a = w_ff[k_ff];
            mul_b = chan;
         end
         default: ;
      endcase
   end

   bce_div u_div0 (
      .clock (clock), .reset (reset), .start (div_start0), .num (div_num0), .den (div_den),
      .busy  (busy0), .quot  (q0)
   );

   bce_div u_div1 (
      .clock (clock), .reset (reset), .start (div_start1), .num (div_num1), .den (div_den),
      .busy  (busy1), .quot  (q1)
   );

   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == bce_pkg::KIND_POINT)
         pt_mem[q_data.slot[bce_pkg::PT_AW-1:0]] <= '{q_data.stamp, q_data.x, q_data.y,
                                                      q_data.z, q_data.s};
      if (pt_re)
         pt_rd_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == bce_pkg::KIND_KNOT)
         kn_mem[q_data.slot] <= q_data.stamp;
      if (kn_re) begin
         kn_a_ff <= kn_mem[ka];
         kn_b_ff <= kn_mem[kb];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign sig_acc = acc_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (q_valid && q_data.kind == bce_pkg::KIND_QUERY) begin
                  t_ff   <= q_data.stamp;
                  idx_ff <= '0;
                  if (cfg.count < IW'(4)) begin
                     spline_ff <= 1'b0;
                     state_ff  <= ST_LSCAN;
                  end else begin
                     spline_ff <= 1'b1;
                     state_ff  <= ST_SPAN_END;
                  end
               end
            end
            ST_LSCAN: begin
               k_ff      <= '0;
               acc_ff    <= '{default: '0};
               w_ff[0]   <= bce_pkg::ONE_Q30;
               if (scan_go) begin
                  prev_ff <= pt_rd_ff.stamp;
                  idx_ff  <= idx_inc;
               end else if (cfg.count == IW'(1) || idx_ff == '0) begin
                  base_ff  <= '0;
                  last_ff  <= '0;
                  state_ff <= ST_BREAD;
               end else if (idx_ff == cfg.count) begin
                  base_ff  <= cfg.count - IW'(1);
                  last_ff  <= '0;
                  state_ff <= ST_BREAD;
               end else begin
                  dt_ff    <= DW'(pt_rd_ff.stamp) - DW'(prev_ff);
                  off_ff   <= DW'(t_ff) - DW'(prev_ff);
                  base_ff  <= idx_ff - IW'(1);
                  last_ff  <= 2'd1;
                  state_ff <= ST_LRATIO;
               end
            end
            ST_LRATIO: begin
               if (off_le0) begin
                  w_ff[0]  <= bce_pkg::ONE_Q30;
                  w_ff[1]  <= '0;
                  state_ff <= ST_BREAD;
               end else if (off_ff >= dtf) begin
                  w_ff[0]  <= '0;
                  w_ff[1]  <= bce_pkg::ONE_Q30;
                  state_ff <= ST_BREAD;
               end else begin
                  state_ff <= ST_LDIV;
               end
            end
            ST_LDIV: begin
               if (!busy0) begin
                  w_ff[0]  <= bce_pkg::ONE_Q30 - q0;
                  w_ff[1]  <= q0;
                  state_ff <= ST_BREAD;
               end
            end
            ST_SPAN_END: begin
               j_ff <= 2'd1;
               if (t_ff >= kn_a_ff) begin
                  span_ff  <= cfg.count - IW'(1);
                  state_ff <= ST_KREAD;
               end else if (t_ff <= kn_b_ff) begin
                  span_ff  <= IW'(cfg.degree);
                  state_ff <= ST_KREAD;
               end else begin
                  low_ff   <= IW'(cfg.degree);
                  high_ff  <= cfg.count;
                  mid_ff   <= sum0[IW:1];
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (search_go) begin
                  low_ff  <= lo_n;
                  high_ff <= hi_n;
                  mid_ff  <= sum_n[IW:1];
               end else begin
                  span_ff  <= mid_ff;
                  state_ff <= ST_KREAD;
               end
            end
            ST_KREAD: begin
               state_ff <= ST_KDATA;
            end
            ST_KDATA: begin
               left_ff[j_ff]  <= DW'(t_ff) - DW'(kn_a_ff);
               right_ff[j_ff] <= DW'(kn_b_ff) - DW'(t_ff);
               if (j_ff == cfg.degree) begin
                  w_ff[0]  <= bce_pkg::ONE_Q30;
                  j_ff     <= 2'd1;
                  r_ff     <= '0;
                  saved_ff <= '0;
                  state_ff <= ST_COX_DIV;
               end else begin
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_KREAD;
               end
            end
            ST_COX_DIV: begin
               state_ff <= ST_COX_WAIT;
            end
            ST_COX_WAIT: begin
               if (!busy0 && !busy1)
                  state_ff <= ST_COX_MA;
            end
            ST_COX_MA: begin
               state_ff <= ST_COX_MB;
            end
            ST_COX_MB: begin
               w_ff[r_ff] <= sat_w(AW'(saved_ff) + AW'(rnd(prod_ff)));
               state_ff   <= ST_COX_MC;
            end
            ST_COX_MC: begin
               if (r_ff == j_ff - 2'd1) begin
                  w_ff[j_ff] <= sv_in;
                  saved_ff   <= '0;
                  r_ff       <= '0;
                  if (j_ff == cfg.degree) begin
                     base_ff  <= span_ff - IW'(cfg.degree);
                     last_ff  <= cfg.degree;
                     k_ff     <= '0;
                     acc_ff   <= '{default: '0};
                     state_ff <= ST_BREAD;
                  end else begin
                     j_ff     <= j_ff + 2'd1;
                     state_ff <= ST_COX_DIV;
                  end
               end else begin
                  saved_ff <= sv_in;
                  r_ff     <= r_inc;
                  state_ff <= ST_COX_DIV;
               end
            end
            ST_BREAD: begin
               c_ff     <= '0;
               state_ff <= ST_BMUL;
            end
            ST_BMUL: begin
               state_ff <= ST_BACC;
            end
            ST_BACC: begin
               acc_ff[c_ff] <= acc_ff[c_ff] + AW'(rnd(prod_ff));
               if (c_ff == 2'd3) begin
                  if (k_ff == last_ff) begin
                     state_ff <= ST_OUT;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= ST_BREAD;
                  end
               end else begin
                  c_ff     <= c_ff + 2'd1;
                  state_ff <= ST_BMUL;
               end
            end
            ST_OUT: begin
               // hold until the output register is free or draining
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.clamped_time <= t_ff;
                  rsp_ff.out_x        <= sat_w(acc_ff[0]);
                  rsp_ff.out_y        <= sat_w(acc_ff[1]);
                  rsp_ff.out_z        <= sat_w(acc_ff[2]);
                  if (sig_acc[AW-1])
                     rsp_ff.out_sigma <= '0;
                  else if (sig_acc > ACC_MAX)
                     rsp_ff.out_sigma <= bce_pkg::W_MAX[bce_pkg::SIG_W-1:0];
                  else
                     rsp_ff.out_sigma <= sig_acc[bce_pkg::SIG_W-1:0];
                  rsp_ff.used_spline  <= spline_ff;
                  rsp_ff.span_index   <= spline_ff ? span_ff : base_ff;
                  state_ff            <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cox_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COX_WAIT && (busy0 || busy1)) |=> state_ff == ST_COX_WAIT)
      else $error("weights advanced while a division was running");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result overwrote an untaken beat");

   a_span_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KREAD |-> (span_ff >= IW'(cfg.degree) && span_ff < cfg.count))
      else $error("knot span outside the valid range");

   a_blend_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BREAD |-> baddr < cfg.count)
      else $error("blend read beyond the points in use");

endmodule
